[rtl/sgkc_pkg.sv]
// ----------------------------------------------------------------------------
// sgkc_pkg
// Shared types, register codes and LFSR step functions for the stop-and-go
// keystream cipher core.
// ----------------------------------------------------------------------------
package sgkc_pkg;

    localparam int LFSR_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SEED_ONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_TWO = 1'd1;

    localparam logic [LFSR_W-1:0] SEED_RESET = 32'h0000_0001;

    typedef logic [LFSR_W-1:0]     lfsr_t;
    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef struct packed {
        lfsr_t one;
        lfsr_t two;
    } lfsr_pair_t;

    typedef struct packed {
        logic advance;
        logic restart;
    } keygen_ctrl_t;

    // right shift, feedback from taps 31, 30, 29, 27, 25 and 0 enters at bit 31
    function automatic lfsr_t lfsr_shift(input lfsr_t x);
        logic fb;
        begin
            fb = x[31] ^ x[30] ^ x[29] ^ x[27] ^ x[25] ^ x[0];
            return {fb, x[LFSR_W-1:1]};
        end
    endfunction

    function automatic logic lfsr_hold(input lfsr_t x);
        return (x[LFSR_W-1] == 1'b0) && (x[LFSR_W-2] == 1'b1);
    endfunction

    // one clock-control step: next state of both registers
    function automatic lfsr_pair_t step_state(input lfsr_pair_t s);
        lfsr_pair_t n;
        begin
            n = s;
            if (lfsr_hold(s.one))
            begin
                n.one = lfsr_shift(s.one);
            end
            else if (lfsr_hold(s.two))
            begin
                n.two = lfsr_shift(s.two);
            end
            else
            begin
                n.one = lfsr_shift(s.one);
                n.two = lfsr_shift(s.two);
            end
            return n;
        end
    endfunction

    // keystream bit of the step from s to n
    function automatic logic step_bit(input lfsr_pair_t s, input lfsr_pair_t n);
        logic b;
        begin
            if (lfsr_hold(s.one))
            begin
                b = n.one[0];
            end
            else if (lfsr_hold(s.two))
            begin
                b = n.two[0];
            end
            else
            begin
                b = n.one[0] ^ n.two[0];
            end
            return b;
        end
    endfunction

endpackage

[rtl/sgkc_in_if.sv]
// ----------------------------------------------------------------------------
// sgkc_in_if
// Input channel: one data byte and a restart flag per word.
// ----------------------------------------------------------------------------
interface sgkc_in_if;

    logic                valid;
    logic                ready;
    sgkc_pkg::byte_t     data_byte;
    logic                restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);

endinterface

[rtl/sgkc_out_if.sv]
// ----------------------------------------------------------------------------
// sgkc_out_if
// Result channel: ciphered byte and keystream byte per word.
// ----------------------------------------------------------------------------
interface sgkc_out_if;

    logic                valid;
    logic                ready;
    sgkc_pkg::byte_t     out_byte;
    sgkc_pkg::byte_t     stream_byte;

    modport source (output valid, output out_byte, output stream_byte, input ready);
    modport sink   (input valid, input out_byte, input stream_byte, output ready);

endinterface

[rtl/sgkc_cfg.sv]
// ----------------------------------------------------------------------------
// sgkc_cfg
// Seed register file written through the plain configuration port.
// ----------------------------------------------------------------------------
module sgkc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  sgkc_pkg::cfg_idx_t  cfg_index,
    input  sgkc_pkg::cfg_data_t cfg_wdata,
    output sgkc_pkg::lfsr_t     seed_one,
    output sgkc_pkg::lfsr_t     seed_two
);
    import sgkc_pkg::*;

    lfsr_t seed_one_reg;
    lfsr_t seed_one_next;
    lfsr_t seed_two_reg;
    lfsr_t seed_two_next;

    always_comb
    begin
        seed_one_next = seed_one_reg;
        seed_two_next = seed_two_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SEED_ONE: seed_one_next = cfg_wdata[LFSR_W-1:0];
                REG_SEED_TWO: seed_two_next = cfg_wdata[LFSR_W-1:0];
                default:
                begin
                    seed_one_next = seed_one_reg;
                    seed_two_next = seed_two_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_one_reg <= SEED_RESET;
            seed_two_reg <= SEED_RESET;
        end
        else
        begin
            seed_one_reg <= seed_one_next;
            seed_two_reg <= seed_two_next;
        end
    end

    assign seed_one = seed_one_reg;
    assign seed_two = seed_two_reg;

endmodule

[rtl/sgkc_keygen.sv]
// ----------------------------------------------------------------------------
// sgkc_keygen
// Two LFSRs, each clock-controlled; eight control steps per byte, unrolled.
// ----------------------------------------------------------------------------
module sgkc_keygen (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sgkc_pkg::keygen_ctrl_t ctrl,
    input  sgkc_pkg::lfsr_t        seed_one,
    input  sgkc_pkg::lfsr_t        seed_two,
    output sgkc_pkg::byte_t        stream_byte
);
    import sgkc_pkg::*;

    lfsr_t      lfsr_one_reg;
    lfsr_t      lfsr_one_next;
    lfsr_t      lfsr_two_reg;
    lfsr_t      lfsr_two_next;
    lfsr_pair_t chain [BYTE_W+1];
    byte_t      ks;

    always_comb
    begin
        // reload from seeds before the byte on restart
        chain[0].one = ctrl.restart ? seed_one : lfsr_one_reg;
        chain[0].two = ctrl.restart ? seed_two : lfsr_two_reg;
        for (int j = 0; j < BYTE_W; j++)
        begin
            chain[j+1] = step_state(chain[j]);
            ks[j]      = step_bit(chain[j], chain[j+1]);
        end
        lfsr_one_next = ctrl.advance ? chain[BYTE_W].one : lfsr_one_reg;
        lfsr_two_next = ctrl.advance ? chain[BYTE_W].two : lfsr_two_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_one_reg <= SEED_RESET;
            lfsr_two_reg <= SEED_RESET;
        end
        else
        begin
            lfsr_one_reg <= lfsr_one_next;
            lfsr_two_reg <= lfsr_two_next;
        end
    end

    assign stream_byte = ks;

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.advance |=> $stable(lfsr_one_reg) && $stable(lfsr_two_reg))
        else $error("LFSR state moved without an advance");

    a_one_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance && !ctrl.restart && (lfsr_one_reg != '0) |=> (lfsr_one_reg != '0))
        else $error("first LFSR collapsed to zero");

    a_two_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance && !ctrl.restart && (lfsr_two_reg != '0) |=> (lfsr_two_reg != '0))
        else $error("second LFSR collapsed to zero");

endmodule

[rtl/stop_and_go_keystream_cipher_core.sv]
// ----------------------------------------------------------------------------
// stop_and_go_keystream_cipher_core
// Byte stream cipher: each word is XORed with one keystream byte taken from
// a pair of clock-controlled LFSRs.
//
//   Channel   | Role  | Word fields              | Handshake
//   ----------+-------+--------------------------+-------------------
//   feed      | sink  | data_byte[7:0], restart  | valid / ready
//   result    | src   | out_byte[7:0], stream_byte[7:0] | valid / ready
//   cfg       | write | cfg_index, cfg_wdata[31:0] | cfg_we, no stall
//
// One word per cycle sustained while result is ready; after feed accept a word
// passes the input register, then the result register, before result is valid.
// The eight LFSR steps of a byte run combinationally between the two registers.
// Reset loads both seeds and both LFSRs with 1; no clearing pass.
// A stalled result holds the input register; feed stays ready while it has room.
// ----------------------------------------------------------------------------
module stop_and_go_keystream_cipher_core (
    input  logic                clk,
    input  logic                rst_n,
    sgkc_in_if.sink             feed,
    sgkc_out_if.source          result,
    input  logic                cfg_we,
    input  sgkc_pkg::cfg_idx_t  cfg_index,
    input  sgkc_pkg::cfg_data_t cfg_wdata
);
    import sgkc_pkg::*;

    logic         feed_valid_reg;
    logic         feed_valid_next;
    byte_t        data_reg;
    byte_t        data_next;
    logic         restart_reg;
    logic         restart_next;
    logic         result_valid_reg;
    logic         result_valid_next;
    byte_t        out_byte_reg;
    byte_t        out_byte_next;
    byte_t        stream_reg;
    byte_t        stream_next;
    logic         accept;
    logic         advance;
    keygen_ctrl_t ctrl;
    lfsr_t        seed_one;
    lfsr_t        seed_two;
    byte_t        ks;

    sgkc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .seed_one  (seed_one),
        .seed_two  (seed_two)
    );

    sgkc_keygen u_keygen (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .seed_one    (seed_one),
        .seed_two    (seed_two),
        .stream_byte (ks)
    );

    assign advance    = feed_valid_reg && (!result_valid_reg || result.ready);
    assign feed.ready = !feed_valid_reg || advance;
    assign accept     = feed.valid && feed.ready;

    assign ctrl.advance = advance;
    assign ctrl.restart = restart_reg;

    always_comb
    begin
        feed_valid_next   = accept ? 1'b1 : (advance ? 1'b0 : feed_valid_reg);
        data_next         = accept ? feed.data_byte : data_reg;
        restart_next      = accept ? feed.restart : restart_reg;
        result_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : result_valid_reg);
        out_byte_next     = advance ? (data_reg ^ ks) : out_byte_reg;
        stream_next       = advance ? ks : stream_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            feed_valid_reg   <= feed_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        restart_reg  <= restart_next;
        out_byte_reg <= out_byte_next;
        stream_reg   <= stream_next;
    end

    assign result.valid       = result_valid_reg;
    assign result.out_byte    = out_byte_reg;
    assign result.stream_byte = stream_reg;

    a_full_blocks_feed: assert property (@(posedge clk) disable iff (!rst_n)
        feed_valid_reg && !advance |-> !feed.ready)
        else $error("feed taken while input register is full and stalled");

    a_result_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(advance))
        else $error("result appeared without an advance");

    a_cipher_relation: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result.out_byte ^ result.stream_byte) == $past(data_reg))
        else $error("result word does not match its input byte");

endmodule
